// File: rtl/dpie_pkg.sv
package dpie_pkg;

    typedef logic [1:0] kind_t;

    // output kinds; also the record kinds held while parsing
    localparam kind_t KIND_COPY = 2'd0;
    localparam kind_t KIND_FILL = 2'd1;
    localparam kind_t KIND_LIT  = 2'd2;

    localparam logic [7:0] TYPE_REPEAT = 8'h52;  // 'R'
    localparam logic [7:0] TYPE_INSERT = 8'h49;  // 'I'

    // register index, paddr[2]
    localparam logic REG_TARGET_SIZE = 1'b0;
    localparam logic REG_SOURCE_SIZE = 1'b1;

endpackage

// File: rtl/delta_patch_instruction_expander.sv
// Chan  Handshake                  Payload
// s_    s_valid s_ready            s_stream_byte (in)
// m_    m_valid m_ready            m_kind m_dest_addr m_src_addr m_run_length m_fill_value (out)
// apb   psel penable pwrite pready paddr pwdata prdata (config write and read)
//
// One byte word is taken per cycle while s_ready is high. The byte that completes a record
// loads stage A; clamp logic sits between stages A, B, C and the output register, and a
// result passes through them in that order. Config is sampled when a record completes.
// aresetn is synchronous; it clears the parser, the size registers and all valids.
// A stall on m_ready backs up through the stages to s_ready.
module delta_patch_instruction_expander #(
    parameter int ADDR_BITS   = 32,
    parameter int FIELD_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_stream_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_dest_addr,
    output logic [31:0] m_src_addr,
    output logic [31:0] m_run_length,
    output logic [7:0]  m_fill_value,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dpie_pkg::*;

    localparam int FW    = 8 * FIELD_BYTES;
    localparam int BIF_W = $clog2(FIELD_BYTES);
    localparam int SZ_W  = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam logic [31:0] SZ_MASK = 32'((33'd1 << SZ_W) - 33'd1);

    localparam logic [2:0] PH_TYPE  = 3'd0;
    localparam logic [2:0] PH_F1    = 3'd1;
    localparam logic [2:0] PH_F2    = 3'd2;
    localparam logic [2:0] PH_F3    = 3'd3;
    localparam logic [2:0] PH_VALUE = 3'd4;
    localparam logic [2:0] PH_LIT   = 3'd5;

    // ---------------- config ----------------
    logic [31:0] target_size_reg;
    logic [31:0] source_size_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_SOURCE_SIZE) ? source_size_reg : target_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_size_reg <= '0;
            source_size_reg <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_TARGET_SIZE) begin
                target_size_reg <= pwdata;
            end else begin
                source_size_reg <= pwdata;
            end
        end
    end

    // ---------------- flow control ----------------
    logic a_valid_reg, b_valid_reg, c_valid_reg, m_valid_reg;
    logic a_free, b_free, c_free, o_free;
    logic s_fire;

    assign o_free  = !m_valid_reg || m_ready;
    assign c_free  = !c_valid_reg || o_free;
    assign b_free  = !b_valid_reg || c_free;
    assign a_free  = !a_valid_reg || b_free;
    assign s_ready = a_free;
    assign s_fire  = s_valid && a_free;

    // ---------------- parser ----------------
    logic [2:0]       phase_reg, phase_next;
    kind_t            op_kind_reg, op_kind_next;
    logic [BIF_W-1:0] bif_reg, bif_next;
    logic [FW-1:0]    field_dest_reg, field_dest_next;
    logic [FW-1:0]    field_second_reg, field_second_next;
    logic [FW-1:0]    field_third_reg, field_third_next;
    logic [FW-1:0]    lit_off_reg, lit_off_next;

    logic [FW-1:0]    field_cur;
    logic [FW-1:0]    acc;
    logic [FW-1:0]    lit_off_inc;
    logic             field_done;
    logic             emit;
    kind_t            emit_kind;
    logic [FW-1:0]    emit_third;
    logic [7:0]       emit_fill;

    always_comb begin
        priority if (phase_reg == PH_F1) begin
            field_cur = field_dest_reg;
        end else if (phase_reg == PH_F2) begin
            field_cur = field_second_reg;
        end else begin
            field_cur = field_third_reg;
        end
    end

    assign acc         = field_cur | (FW'(s_stream_byte) << {bif_reg, 3'b000});
    assign field_done  = (bif_reg == BIF_W'(FIELD_BYTES - 1));
    assign lit_off_inc = lit_off_reg + FW'(1);

    always_comb begin
        phase_next        = phase_reg;
        op_kind_next      = op_kind_reg;
        bif_next          = bif_reg;
        field_dest_next   = field_dest_reg;
        field_second_next = field_second_reg;
        field_third_next  = field_third_reg;
        lit_off_next      = lit_off_reg;
        emit              = 1'b0;
        emit_kind         = KIND_COPY;
        emit_third        = field_third_reg;
        emit_fill         = 8'd0;

        unique case (phase_reg)
            PH_TYPE: begin
                if (s_stream_byte == TYPE_REPEAT) begin
                    op_kind_next = KIND_FILL;
                end else if (s_stream_byte == TYPE_INSERT) begin
                    op_kind_next = KIND_LIT;
                end else begin
                    op_kind_next = KIND_COPY;
                end
                phase_next      = PH_F1;
                bif_next        = '0;
                field_dest_next = '0;
            end
            PH_F1, PH_F2, PH_F3: begin
                bif_next = bif_reg + BIF_W'(1);
                if (phase_reg == PH_F1) field_dest_next = acc;
                if (phase_reg == PH_F2) field_second_next = acc;
                if (phase_reg == PH_F3) field_third_next = acc;
                if (field_done) begin
                    bif_next = '0;
                    if (phase_reg == PH_F1) begin
                        phase_next        = PH_F2;
                        field_second_next = '0;
                    end else if (phase_reg == PH_F2) begin
                        if (op_kind_reg == KIND_COPY) begin
                            phase_next       = PH_F3;
                            field_third_next = '0;
                        end else if (op_kind_reg == KIND_FILL) begin
                            phase_next = PH_VALUE;
                        end else begin
                            lit_off_next = '0;
                            phase_next   = (acc == '0) ? PH_TYPE : PH_LIT;
                        end
                    end else begin
                        phase_next = PH_TYPE;
                        emit       = 1'b1;
                        emit_kind  = KIND_COPY;
                        emit_third = acc;
                    end
                end
            end
            PH_VALUE: begin
                phase_next = PH_TYPE;
                emit       = 1'b1;
                emit_kind  = KIND_FILL;
                emit_fill  = s_stream_byte;
            end
            PH_LIT: begin
                lit_off_next = lit_off_inc;
                if (lit_off_inc >= field_second_reg) phase_next = PH_TYPE;
                emit      = 1'b1;
                emit_kind = KIND_LIT;
                emit_fill = s_stream_byte;
            end
            default: begin
                phase_next = PH_TYPE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_TYPE;
            op_kind_reg      <= KIND_COPY;
            bif_reg          <= '0;
            field_dest_reg   <= '0;
            field_second_reg <= '0;
            field_third_reg  <= '0;
            lit_off_reg      <= '0;
        end else if (s_fire) begin
            phase_reg        <= phase_next;
            op_kind_reg      <= op_kind_next;
            bif_reg          <= bif_next;
            field_dest_reg   <= field_dest_next;
            field_second_reg <= field_second_next;
            field_third_reg  <= field_third_next;
            lit_off_reg      <= lit_off_next;
        end
    end

    // ---------------- stage A: completed record ----------------
    kind_t         a_kind_reg;
    logic [FW-1:0] a_dest_reg, a_second_reg, a_third_reg, a_off_reg;
    logic [7:0]    a_fill_reg;
    logic [31:0]   a_tsz_reg, a_ssz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_free) begin
            a_valid_reg <= s_fire && emit;
        end
        if (s_fire) begin
            a_kind_reg   <= emit_kind;
            a_dest_reg   <= field_dest_reg;
            a_second_reg <= field_second_reg;
            a_third_reg  <= emit_third;
            a_off_reg    <= lit_off_reg;
            a_fill_reg   <= emit_fill;
            a_tsz_reg    <= target_size_reg & SZ_MASK;
            a_ssz_reg    <= source_size_reg & SZ_MASK;
        end
    end

    // room in target, and read end clipped to the source
    logic [31:0] a_room_t, a_lim, a_dest_w;

    always_comb begin
        a_room_t = (a_dest_reg < FW'(a_tsz_reg)) ? (a_tsz_reg - a_dest_reg[31:0]) : 32'd0;
        a_lim    = (a_third_reg < FW'(a_ssz_reg)) ? a_third_reg[31:0] : a_ssz_reg;
        a_dest_w = (a_kind_reg == KIND_LIT) ? (a_dest_reg[31:0] + a_off_reg[31:0])
                                            : a_dest_reg[31:0];
    end

    // ---------------- stage B ----------------
    kind_t         b_kind_reg;
    logic [31:0]   b_room_t_reg, b_lim_reg, b_dest_reg, b_src_reg;
    logic [FW-1:0] b_second_reg, b_off_reg;
    logic [7:0]    b_fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_free) begin
            b_valid_reg <= a_valid_reg;
        end
        if (b_free) begin
            b_kind_reg   <= a_kind_reg;
            b_room_t_reg <= a_room_t;
            b_lim_reg    <= a_lim;
            b_dest_reg   <= a_dest_w;
            b_src_reg    <= a_second_reg[31:0];
            b_second_reg <= a_second_reg;
            b_off_reg    <= a_off_reg;
            b_fill_reg   <= a_fill_reg;
        end
    end

    logic [FW-1:0] b_room_s;
    logic          b_hit;

    always_comb begin
        if (b_kind_reg == KIND_COPY) begin
            b_room_s = (b_second_reg < FW'(b_lim_reg))
                     ? FW'(b_lim_reg - b_second_reg[31:0]) : '0;
        end else begin
            b_room_s = b_second_reg;
        end
        b_hit = (b_off_reg < FW'(b_room_t_reg));
    end

    // ---------------- stage C ----------------
    kind_t         c_kind_reg;
    logic [31:0]   c_room_t_reg, c_dest_reg, c_src_reg;
    logic [FW-1:0] c_room_s_reg;
    logic          c_hit_reg;
    logic [7:0]    c_fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_free) begin
            c_valid_reg <= b_valid_reg;
        end
        if (c_free) begin
            c_kind_reg   <= b_kind_reg;
            c_room_t_reg <= b_room_t_reg;
            c_room_s_reg <= b_room_s;
            c_hit_reg    <= b_hit;
            c_dest_reg   <= b_dest_reg;
            c_src_reg    <= b_src_reg;
            c_fill_reg   <= b_fill_reg;
        end
    end

    logic        c_keep;
    logic [31:0] c_len;

    always_comb begin
        if (c_kind_reg == KIND_LIT) begin
            c_keep = c_hit_reg;
            c_len  = 32'd1;
        end else begin
            // zero-length runs are dropped here
            c_keep = (c_room_t_reg != 32'd0) && (c_room_s_reg != '0);
            c_len  = (c_room_s_reg < FW'(c_room_t_reg)) ? c_room_s_reg[31:0] : c_room_t_reg;
        end
    end

    // ---------------- output register ----------------
    kind_t       m_kind_reg;
    logic [31:0] m_dest_reg, m_src_reg, m_len_reg;
    logic [7:0]  m_fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (o_free) begin
            m_valid_reg <= c_valid_reg && c_keep;
        end
        if (o_free) begin
            m_kind_reg <= c_kind_reg;
            m_dest_reg <= c_dest_reg;
            m_src_reg  <= (c_kind_reg == KIND_COPY) ? c_src_reg : 32'd0;
            m_len_reg  <= c_len;
            m_fill_reg <= (c_kind_reg == KIND_COPY) ? 8'd0 : c_fill_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_dest_addr  = m_dest_reg;
    assign m_src_addr   = m_src_reg;
    assign m_run_length = m_len_reg;
    assign m_fill_value = m_fill_reg;

`ifndef SYNTHESIS
    a_lit_phase_op: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_LIT |-> op_kind_reg == KIND_LIT)
        else $error("literal phase outside an insert record");

    a_bif_in_field: assert property (@(posedge aclk) disable iff (!aresetn)
        bif_reg != '0 |-> (phase_reg == PH_F1 || phase_reg == PH_F2 || phase_reg == PH_F3))
        else $error("byte count set outside a field");

    a_no_zero_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_run_length != 32'd0)
        else $error("zero-length result");

    a_lit_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_LIT |-> m_run_length == 32'd1 && m_src_addr == 32'd0)
        else $error("literal result malformed");
`endif

endmodule
